/* hw/rtl/lbi_pkg.sv */
// Shared payload types and fixed-point constants for the light bounds importance block.
`timescale 1ns / 1ps

package lbi_pkg;

  // One input transfer: cluster bounds plus the shading point and its normal
  typedef struct packed {
    logic        [47:0] box_min;
    logic        [47:0] box_max;
    logic        [47:0] cone_axis;
    logic signed [15:0] cos_spread;
    logic signed [15:0] cos_falloff;
    logic        [31:0] power;
    logic               two_sided;
    logic        [47:0] shade_point;
    logic        [47:0] shade_normal;
  } lbi_in_t;

  // One result transfer
  typedef struct packed {
    logic [31:0] importance;
    logic        outside_falloff;
  } lbi_out_t;

  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [15:0] NEG_ONE_Q14 = -16'sd16384;
  localparam logic        [14:0] UNIT_MAG    = 15'd16384;
  localparam logic        [29:0] ONE_Q28     = 30'd268435456;

endpackage

/* hw/rtl/light_bounds_importance.sv */
// Top level: fully pipelined light cluster importance estimator.
`timescale 1ns / 1ps

// The block takes one item per clock while the output is not stalled and
// returns one result per item, in order. The depth is set by the
// bit-per-stage chains: the 32-stage square root of the scaled squared
// distance, the 15-stage cosine quotients and sine roots, and the 32-stage
// quotient of the final importance divide. All stages advance together; while
// a result waits at the output, in_ready is low and the whole pipe holds, so
// no item is dropped or repeated.
module light_bounds_importance (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lbi_pkg::lbi_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lbi_pkg::lbi_out_t out_data
);
  import lbi_pkg::*;

  localparam int LAT = 105;

  // ---------------------------------------------------------------------
  // Stage record types
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [63:0]        lv;
    logic [63:0]        lr;
    logic [51:0]        hv;
    logic [51:0]        hr;
    logic [29:0]        sv;
    logic [29:0]        sr;
    logic [36:0]        qrem;
    logic [28:0]        qt;
    logic [35:0]        dist2;
    logic               full;
    logic signed [35:0] numw;
    logic signed [35:0] numi;
    logic signed [15:0] co;
    logic signed [15:0] ce;
    logic [31:0]        phi;
    logic               two;
  } a_t;

  typedef struct packed {
    logic [47:0]        wrem;
    logic [47:0]        irem;
    logic [14:0]        wq;
    logic [14:0]        iq;
    logic               wovf;
    logic               iovf;
    logic               wneg;
    logic               zlen;
    logic [31:0]        len;
    logic [29:0]        bv;
    logic [29:0]        br;
    logic [29:0]        cv;
    logic [29:0]        cr;
    logic [35:0]        dist2;
    logic [25:0]        hd;
    logic               full;
    logic [14:0]        so;
    logic signed [15:0] co;
    logic signed [15:0] ce;
    logic [31:0]        phi;
    logic               two;
  } b_t;

  typedef struct packed {
    logic signed [15:0] cw;
    logic [14:0]        ci;
    logic [29:0]        wv;
    logic [29:0]        wr;
    logic [29:0]        iv;
    logic [29:0]        ir;
    logic [14:0]        sb;
    logic signed [15:0] cb;
    logic [14:0]        so;
    logic signed [15:0] co;
    logic signed [15:0] ce;
    logic [31:0]        phi;
    logic [35:0]        dist2;
    logic [25:0]        hd;
  } e_t;

  typedef struct packed {
    logic signed [29:0] p1;
    logic signed [29:0] p2;
    logic signed [29:0] p3;
    logic signed [29:0] p4;
    logic signed [29:0] p5;
    logic signed [29:0] p6;
    logic               gtw;
    logic               gti;
    logic [14:0]        sb;
    logic signed [15:0] cb;
    logic signed [15:0] ce;
    logic [31:0]        phi;
    logic [35:0]        dist2;
    logic [25:0]        hd;
  } f_t;

  typedef struct packed {
    logic signed [15:0] cwo;
    logic signed [15:0] swo;
    logic signed [15:0] cib;
    logic [14:0]        sb;
    logic signed [15:0] cb;
    logic signed [15:0] ce;
    logic [31:0]        phi;
    logic [35:0]        dist2;
    logic [25:0]        hd;
  } g_t;

  typedef struct packed {
    logic signed [29:0] q1;
    logic signed [29:0] q2;
    logic               gtp;
    logic signed [15:0] cib;
    logic signed [15:0] ce;
    logic [31:0]        phi;
    logic [35:0]        dist2;
    logic [25:0]        hd;
  } h_t;

  typedef struct packed {
    logic signed [15:0] cp;
    logic signed [15:0] cib;
    logic signed [15:0] ce;
    logic [31:0]        phi;
    logic [35:0]        dist2;
    logic [25:0]        hd;
  } i_t;

  typedef struct packed {
    logic [28:0] m1;
    logic        cut;
    logic        zero;
    logic [31:0] phi;
    logic [35:0] dmax;
  } j_t;

  typedef struct packed {
    logic [60:0] num;
    logic [45:0] dv;
    logic        cut;
    logic        zero;
  } k_t;

  typedef struct packed {
    logic [60:0] rem;
    logic [31:0] q;
    logic [45:0] dv;
    logic        sat;
    logic        cut;
    logic        zero;
  } l_t;

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [15:0] lane(input logic [47:0] v, input int i);
    lane = $signed(v[16*i +: 16]);
  endfunction

  // Floor divide by 2^14, then clamp to the unit range
  function automatic logic signed [15:0] fq14c(input logic signed [30:0] s);
    logic signed [16:0] f;
    f = 17'(s >>> 14);
    if (f > 17'sd16384) fq14c = ONE_Q14;
    else if (f < -17'sd16384) fq14c = NEG_ONE_Q14;
    else fq14c = 16'(f);
  endfunction

  // Quotient magnitude clamped to one, zero when there is no direction
  function automatic logic [14:0] qclamp(input logic [14:0] q, input logic ovf,
                                          input logic zl);
    if (zl) qclamp = '0;
    else if (ovf || (q > UNIT_MAG)) qclamp = UNIT_MAG;
    else qclamp = q;
  endfunction

  // ---------------------------------------------------------------------
  // Handshake and valid chain
  // ---------------------------------------------------------------------
  logic [LAT-1:0] vld_r;
  logic           adv;
  lbi_out_t       out_r;

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: offsets from centroid (doubled) and box extents
  // ---------------------------------------------------------------------
  logic signed [17:0] d1_r [3];
  logic signed [16:0] e1_r [3];
  logic signed [15:0] ax1_r [3];
  logic signed [15:0] nm1_r [3];
  logic signed [15:0] co1_r, ce1_r;
  logic [31:0]        phi1_r;
  logic               two1_r;
  logic signed [17:0] d1_nxt [3];
  logic signed [16:0] e1_nxt [3];
  logic signed [15:0] co1_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = (18'(lane(in_data.shade_point, i)) <<< 1)
                - (18'(lane(in_data.box_min, i)) + 18'(lane(in_data.box_max, i)));
      e1_nxt[i] = 17'(lane(in_data.box_max, i)) - 17'(lane(in_data.box_min, i));
    end
    if (in_data.cos_spread > ONE_Q14) co1_nxt = ONE_Q14;
    else if (in_data.cos_spread < NEG_ONE_Q14) co1_nxt = NEG_ONE_Q14;
    else co1_nxt = in_data.cos_spread;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= d1_nxt[i];
        e1_r[i]  <= e1_nxt[i];
        ax1_r[i] <= lane(in_data.cone_axis, i);
        nm1_r[i] <= lane(in_data.shade_normal, i);
      end
      co1_r  <= co1_nxt;
      ce1_r  <= in_data.cos_falloff;
      phi1_r <= in_data.power;
      two1_r <= in_data.two_sided;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: per-lane products
  // ---------------------------------------------------------------------
  logic [33:0]        dd2_r [3];
  logic [31:0]        ee2_r [3];
  logic signed [33:0] pw2_r [3];
  logic signed [33:0] pn2_r [3];
  logic [29:0]        sov2_r;
  logic signed [15:0] co2_r, ce2_r;
  logic [31:0]        phi2_r;
  logic               two2_r;
  logic [33:0]        dd2_nxt [3];
  logic [31:0]        ee2_nxt [3];
  logic signed [33:0] pw2_nxt [3];
  logic signed [33:0] pn2_nxt [3];
  logic [29:0]        sov2_nxt;

  always_comb begin
    logic signed [35:0] td;
    logic signed [33:0] te;
    logic [14:0]        com;
    for (int i = 0; i < 3; i++) begin
      td         = d1_r[i] * d1_r[i];
      te         = e1_r[i] * e1_r[i];
      dd2_nxt[i] = td[33:0];
      ee2_nxt[i] = te[31:0];
      pw2_nxt[i] = d1_r[i] * ax1_r[i];
      pn2_nxt[i] = d1_r[i] * nm1_r[i];
    end
    com      = co1_r[15] ? 15'(-co1_r) : co1_r[14:0];
    sov2_nxt = ONE_Q28 - 30'(com * com);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd2_r  <= dd2_nxt;
      ee2_r  <= ee2_nxt;
      pw2_r  <= pw2_nxt;
      pn2_r  <= pn2_nxt;
      sov2_r <= sov2_nxt;
      co2_r  <= co1_r;
      ce2_r  <= ce1_r;
      phi2_r <= phi1_r;
      two2_r <= two1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: lane sums
  // ---------------------------------------------------------------------
  logic [35:0]        dist2_3_r;
  logic [33:0]        diag2_3_r;
  logic signed [35:0] numw3_r, numi3_r;
  logic [29:0]        sov3_r;
  logic signed [15:0] co3_r, ce3_r;
  logic [31:0]        phi3_r;
  logic               two3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dist2_3_r <= {2'b0, dd2_r[0]} + {2'b0, dd2_r[1]} + {2'b0, dd2_r[2]};
      diag2_3_r <= {2'b0, ee2_r[0]} + {2'b0, ee2_r[1]} + {2'b0, ee2_r[2]};
      numw3_r   <= 36'(pw2_r[0]) + 36'(pw2_r[1]) + 36'(pw2_r[2]);
      numi3_r   <= 36'(pn2_r[0]) + 36'(pn2_r[1]) + 36'(pn2_r[2]);
      sov3_r    <= sov2_r;
      co3_r     <= co2_r;
      ce3_r     <= ce2_r;
      phi3_r    <= phi2_r;
      two3_r    <= two2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Segment A: distance root, half-diagonal root, spread sine, sphere sin^2
  // ---------------------------------------------------------------------
  a_t a_init;
  a_t a_in  [32];
  a_t a_nxt [32];
  a_t a_r   [32];

  always_comb begin
    a_init       = '0;
    a_init.lv    = {dist2_3_r, 28'b0};
    a_init.hv    = {diag2_3_r, 18'b0};
    a_init.sv    = sov3_r;
    a_init.qrem  = {3'b0, diag2_3_r};
    a_init.dist2 = dist2_3_r;
    a_init.full  = (dist2_3_r == '0) || (dist2_3_r < {2'b0, diag2_3_r});
    a_init.numw  = numw3_r;
    a_init.numi  = numi3_r;
    a_init.co    = co3_r;
    a_init.ce    = ce3_r;
    a_init.phi   = phi3_r;
    a_init.two   = two3_r;
  end

  for (genvar j = 0; j < 32; j++) begin : g_a
    localparam int LS = 62 - 2*j;
    localparam int HS = (j < 26) ? 50 - 2*j : 0;
    localparam int SS = (j < 15) ? 28 - 2*j : 0;

    if (j == 0) begin : g_first
      assign a_in[j] = a_init;
    end else begin : g_next
      assign a_in[j] = a_r[j-1];
    end

    // One root bit for each unfinished chain, one quotient bit for sin^2 until it is complete
    always_comb begin : c_step
      logic [64:0] lsum;
      logic [52:0] hsum;
      logic [30:0] ssum;
      logic [36:0] rem;
      logic [28:0] qq;
      a_nxt[j] = a_in[j];
      lsum = {1'b0, a_in[j].lr} + (65'd1 << LS);
      if ({1'b0, a_in[j].lv} >= lsum) begin
        a_nxt[j].lv = a_in[j].lv - lsum[63:0];
        a_nxt[j].lr = (a_in[j].lr >> 1) + (64'd1 << LS);
      end else begin
        a_nxt[j].lr = a_in[j].lr >> 1;
      end
      hsum = {1'b0, a_in[j].hr} + (53'd1 << HS);
      if (j < 26) begin
        if ({1'b0, a_in[j].hv} >= hsum) begin
          a_nxt[j].hv = a_in[j].hv - hsum[51:0];
          a_nxt[j].hr = (a_in[j].hr >> 1) + (52'd1 << HS);
        end else begin
          a_nxt[j].hr = a_in[j].hr >> 1;
        end
      end
      ssum = {1'b0, a_in[j].sr} + (31'd1 << SS);
      if (j < 15) begin
        if ({1'b0, a_in[j].sv} >= ssum) begin
          a_nxt[j].sv = a_in[j].sv - ssum[29:0];
          a_nxt[j].sr = (a_in[j].sr >> 1) + (30'd1 << SS);
        end else begin
          a_nxt[j].sr = a_in[j].sr >> 1;
        end
      end
      rem = a_in[j].qrem;
      qq  = a_in[j].qt;
      if (j < 29) begin
        if (j > 0) begin
          rem = {rem[35:0], 1'b0};
          qq  = {qq[27:0], 1'b0};
        end
        if (rem >= {1'b0, a_in[j].dist2}) begin
          rem   = rem - {1'b0, a_in[j].dist2};
          qq[0] = 1'b1;
        end
      end
      a_nxt[j].qrem = rem;
      a_nxt[j].qt   = qq;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_r[j] <= a_nxt[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Segment B: cosine quotients and sphere sine/cosine roots
  // ---------------------------------------------------------------------
  b_t b_init;
  b_t b_in  [15];
  b_t b_nxt [15];
  b_t b_r   [15];

  always_comb begin
    logic [35:0] mw;
    logic [35:0] mi;
    mw = a_r[31].numw[35] ? 36'(-a_r[31].numw) : 36'(a_r[31].numw);
    mi = a_r[31].numi[35] ? 36'(-a_r[31].numi) : 36'(a_r[31].numi);
    b_init       = '0;
    b_init.len   = a_r[31].lr[31:0];
    b_init.wrem  = {mw[33:0], 14'b0};
    b_init.irem  = {mi[33:0], 14'b0};
    b_init.wovf  = {mw[33:0], 14'b0} >= {1'b0, a_r[31].lr[31:0], 15'b0};
    b_init.iovf  = {mi[33:0], 14'b0} >= {1'b0, a_r[31].lr[31:0], 15'b0};
    b_init.wneg  = a_r[31].numw[35];
    b_init.zlen  = (a_r[31].lr[31:0] == '0);
    b_init.bv    = {1'b0, a_r[31].qt};
    b_init.cv    = ONE_Q28 - {1'b0, a_r[31].qt};
    b_init.dist2 = a_r[31].dist2;
    b_init.hd    = a_r[31].hr[25:0];
    b_init.full  = a_r[31].full;
    b_init.so    = a_r[31].sr[14:0];
    b_init.co    = a_r[31].co;
    b_init.ce    = a_r[31].ce;
    b_init.phi   = a_r[31].phi;
    b_init.two   = a_r[31].two;
  end

  for (genvar j = 0; j < 15; j++) begin : g_b
    localparam int K  = 14 - j;
    localparam int SB = 28 - 2*j;

    if (j == 0) begin : g_first
      assign b_in[j] = b_init;
    end else begin : g_next
      assign b_in[j] = b_r[j-1];
    end

    always_comb begin : c_step
      logic [47:0] dsh;
      logic [30:0] bsum;
      logic [30:0] csum;
      b_nxt[j] = b_in[j];
      dsh = {16'b0, b_in[j].len} << K;
      if (b_in[j].wrem >= dsh) begin
        b_nxt[j].wrem  = b_in[j].wrem - dsh;
        b_nxt[j].wq[K] = 1'b1;
      end
      if (b_in[j].irem >= dsh) begin
        b_nxt[j].irem  = b_in[j].irem - dsh;
        b_nxt[j].iq[K] = 1'b1;
      end
      bsum = {1'b0, b_in[j].br} + (31'd1 << SB);
      if ({1'b0, b_in[j].bv} >= bsum) begin
        b_nxt[j].bv = b_in[j].bv - bsum[29:0];
        b_nxt[j].br = (b_in[j].br >> 1) + (30'd1 << SB);
      end else begin
        b_nxt[j].br = b_in[j].br >> 1;
      end
      csum = {1'b0, b_in[j].cr} + (31'd1 << SB);
      if ({1'b0, b_in[j].cv} >= csum) begin
        b_nxt[j].cv = b_in[j].cv - csum[29:0];
        b_nxt[j].cr = (b_in[j].cr >> 1) + (30'd1 << SB);
      end else begin
        b_nxt[j].cr = b_in[j].cr >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        b_r[j] <= b_nxt[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: finish cosines, select sphere terms, seed the sine roots
  // ---------------------------------------------------------------------
  e_t c_nxt;
  e_t c_r;

  always_comb begin
    logic [14:0] qw;
    logic [14:0] qi;
    qw = qclamp(b_r[14].wq, b_r[14].wovf, b_r[14].zlen);
    qi = qclamp(b_r[14].iq, b_r[14].iovf, b_r[14].zlen);
    c_nxt       = '0;
    c_nxt.cw    = (b_r[14].two || !b_r[14].wneg) ? $signed({1'b0, qw})
                                                 : -$signed({1'b0, qw});
    c_nxt.ci    = qi;
    c_nxt.wv    = ONE_Q28 - 30'(qw * qw);
    c_nxt.iv    = ONE_Q28 - 30'(qi * qi);
    c_nxt.sb    = b_r[14].full ? '0 : b_r[14].br[14:0];
    c_nxt.cb    = b_r[14].full ? NEG_ONE_Q14 : $signed({1'b0, b_r[14].cr[14:0]});
    c_nxt.so    = b_r[14].so;
    c_nxt.co    = b_r[14].co;
    c_nxt.ce    = b_r[14].ce;
    c_nxt.phi   = b_r[14].phi;
    c_nxt.dist2 = b_r[14].dist2;
    c_nxt.hd    = b_r[14].hd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= c_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Segment E: sines of the axis and normal cosines
  // ---------------------------------------------------------------------
  e_t e_in  [15];
  e_t e_nxt [15];
  e_t e_r   [15];

  for (genvar j = 0; j < 15; j++) begin : g_e
    localparam int SB = 28 - 2*j;

    if (j == 0) begin : g_first
      assign e_in[j] = c_r;
    end else begin : g_next
      assign e_in[j] = e_r[j-1];
    end

    always_comb begin : c_step
      logic [30:0] wsum;
      logic [30:0] isum;
      e_nxt[j] = e_in[j];
      wsum = {1'b0, e_in[j].wr} + (31'd1 << SB);
      if ({1'b0, e_in[j].wv} >= wsum) begin
        e_nxt[j].wv = e_in[j].wv - wsum[29:0];
        e_nxt[j].wr = (e_in[j].wr >> 1) + (30'd1 << SB);
      end else begin
        e_nxt[j].wr = e_in[j].wr >> 1;
      end
      isum = {1'b0, e_in[j].ir} + (31'd1 << SB);
      if ({1'b0, e_in[j].iv} >= isum) begin
        e_nxt[j].iv = e_in[j].iv - isum[29:0];
        e_nxt[j].ir = (e_in[j].ir >> 1) + (30'd1 << SB);
      end else begin
        e_nxt[j].ir = e_in[j].ir >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        e_r[j] <= e_nxt[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage F: products for the axis-minus-spread and incidence differences
  // ---------------------------------------------------------------------
  f_t f_nxt;
  f_t f_r;

  always_comb begin
    logic signed [15:0] sw;
    logic signed [15:0] si;
    logic signed [15:0] so;
    logic signed [15:0] ci;
    logic signed [15:0] sb;
    sw = $signed({1'b0, e_r[14].wr[14:0]});
    si = $signed({1'b0, e_r[14].ir[14:0]});
    so = $signed({1'b0, e_r[14].so});
    ci = $signed({1'b0, e_r[14].ci});
    sb = $signed({1'b0, e_r[14].sb});
    f_nxt.p1    = e_r[14].cw * e_r[14].co;
    f_nxt.p2    = sw * so;
    f_nxt.p3    = sw * e_r[14].co;
    f_nxt.p4    = e_r[14].cw * so;
    f_nxt.p5    = ci * e_r[14].cb;
    f_nxt.p6    = si * sb;
    f_nxt.gtw   = e_r[14].cw > e_r[14].co;
    f_nxt.gti   = ci > e_r[14].cb;
    f_nxt.sb    = e_r[14].sb;
    f_nxt.cb    = e_r[14].cb;
    f_nxt.ce    = e_r[14].ce;
    f_nxt.phi   = e_r[14].phi;
    f_nxt.dist2 = e_r[14].dist2;
    f_nxt.hd    = e_r[14].hd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r <= f_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage G: clamped angle subtraction
  // ---------------------------------------------------------------------
  g_t g_nxt;
  g_t g_r;

  always_comb begin
    g_nxt.cwo   = f_r.gtw ? ONE_Q14 : fq14c(31'(f_r.p1) + 31'(f_r.p2));
    g_nxt.swo   = f_r.gtw ? 16'sd0  : fq14c(31'(f_r.p3) - 31'(f_r.p4));
    g_nxt.cib   = f_r.gti ? ONE_Q14 : fq14c(31'(f_r.p5) + 31'(f_r.p6));
    g_nxt.sb    = f_r.sb;
    g_nxt.cb    = f_r.cb;
    g_nxt.ce    = f_r.ce;
    g_nxt.phi   = f_r.phi;
    g_nxt.dist2 = f_r.dist2;
    g_nxt.hd    = f_r.hd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r <= g_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage H: products for subtracting the sphere angle
  // ---------------------------------------------------------------------
  h_t h_nxt;
  h_t h_r;

  always_comb begin
    h_nxt.q1    = g_r.cwo * g_r.cb;
    h_nxt.q2    = g_r.swo * $signed({1'b0, g_r.sb});
    h_nxt.gtp   = g_r.cwo > g_r.cb;
    h_nxt.cib   = g_r.cib;
    h_nxt.ce    = g_r.ce;
    h_nxt.phi   = g_r.phi;
    h_nxt.dist2 = g_r.dist2;
    h_nxt.hd    = g_r.hd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_r <= h_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage I: cosine of the remaining emission angle
  // ---------------------------------------------------------------------
  i_t i_nxt;
  i_t i_r;

  always_comb begin
    i_nxt.cp    = h_r.gtp ? ONE_Q14 : fq14c(31'(h_r.q1) + 31'(h_r.q2));
    i_nxt.cib   = h_r.cib;
    i_nxt.ce    = h_r.ce;
    i_nxt.phi   = h_r.phi;
    i_nxt.dist2 = h_r.dist2;
    i_nxt.hd    = h_r.hd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_r <= i_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage J: falloff test, cosine product, clamped distance
  // ---------------------------------------------------------------------
  j_t j_nxt;
  j_t j_r;

  always_comb begin
    j_nxt.cut  = i_r.cp <= i_r.ce;
    j_nxt.zero = (i_r.cib <= 16'sd0) || (i_r.cp <= 16'sd0) || (i_r.phi == '0);
    j_nxt.m1   = i_r.cib[14:0] * i_r.cp[14:0];
    j_nxt.phi  = i_r.phi;
    j_nxt.dmax = (i_r.dist2 > {10'b0, i_r.hd}) ? i_r.dist2 : {10'b0, i_r.hd};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_r <= j_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage K: numerator and scaled denominator
  // ---------------------------------------------------------------------
  k_t k_nxt;
  k_t k_r;

  always_comb begin
    k_nxt.num  = j_r.phi * j_r.m1;
    k_nxt.dv   = {j_r.dmax, 10'b0};
    k_nxt.cut  = j_r.cut;
    k_nxt.zero = j_r.zero;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r <= k_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Segment L: 32-bit restoring quotient with saturation
  // ---------------------------------------------------------------------
  l_t l_init;
  l_t l_in  [32];
  l_t l_nxt [32];
  l_t l_r   [32];

  always_comb begin
    l_init      = '0;
    l_init.rem  = k_r.num;
    l_init.dv   = k_r.dv;
    l_init.sat  = {17'b0, k_r.num[60:32]} >= k_r.dv;
    l_init.cut  = k_r.cut;
    l_init.zero = k_r.zero;
  end

  for (genvar j = 0; j < 32; j++) begin : g_l
    localparam int K = 31 - j;

    if (j == 0) begin : g_first
      assign l_in[j] = l_init;
    end else begin : g_next
      assign l_in[j] = l_r[j-1];
    end

    always_comb begin : c_step
      logic [60:0] sh;
      l_nxt[j] = l_in[j];
      sh = l_in[j].rem >> K;
      if (sh >= {15'b0, l_in[j].dv}) begin
        l_nxt[j].rem  = l_in[j].rem - ({15'b0, l_in[j].dv} << K);
        l_nxt[j].q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        l_r[j] <= l_nxt[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      if (l_r[31].cut || l_r[31].zero) begin
        out_r.importance <= '0;
      end else if (l_r[31].sat) begin
        out_r.importance <= '1;
      end else begin
        out_r.importance <= l_r[31].q;
      end
      out_r.outside_falloff <= l_r[31].cut;
    end
  end

endmodule

/* hw/rtl/lbi_checker.sv */
// Port-level checker for the light bounds importance block, bound to the top level.
`timescale 1ns / 1ps

module lbi_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input lbi_pkg::lbi_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input lbi_pkg::lbi_out_t out_data
);
  import lbi_pkg::*;

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Keep the pipe open while no result waits
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty output");

  // Freeze the pipe on an output stall
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // Drop importance to zero on a falloff cut
  a_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outside_falloff |-> out_data.importance == '0)
    else $error("falloff cut with nonzero importance");

  // Empty the output after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind light_bounds_importance lbi_checker u_lbi_checker (.*);

/* bench/light_bounds_importance_tb.sv */
// Self-checking testbench for the light bounds importance estimator.
`timescale 1ns / 1ps

// Scoreboard: predicts each importance result from an accepted input and
// checks results in order.
class importance_scoreboard;
  lbi_pkg::lbi_out_t pending[$];
  int unsigned errors;
  int unsigned matched;

  function new();
    errors  = 0;
    matched = 0;
  endfunction

  static function longint lane_of(bit [47:0] v, int i);
    return longint'($signed(v[16*i +: 16]));
  endfunction

  static function longint clamp_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  static function bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function longint sine_of(longint c);
    longint cc;
    cc = clamp_unit(c);
    return longint'(floor_sqrt(64'(268435456 - cc * cc)));
  endfunction

  static function longint floor_q14(longint v);
    if (v >= 0) return v >>> 14;
    return -(((-v) + 16383) >>> 14);
  endfunction

  static function longint angle_cos(longint sa, longint ca, longint sb, longint cb);
    if (ca > cb) return 16384;
    return clamp_unit(floor_q14(ca * cb + sa * sb));
  endfunction

  static function longint angle_sin(longint sa, longint ca, longint sb, longint cb);
    if (ca > cb) return 0;
    return clamp_unit(floor_q14(sa * cb - ca * sb));
  endfunction

  static function longint dir_cos(longint dx, longint dy, longint dz, bit [47:0] vec,
                                  bit [63:0] len);
    longint num;
    if (len == 0) return 0;
    num = dx * lane_of(vec, 0) + dy * lane_of(vec, 1) + dz * lane_of(vec, 2);
    return clamp_unit((num * 16384) / longint'(len));
  endfunction

  // Work out the expected result of one item
  static function lbi_pkg::lbi_out_t estimate(lbi_pkg::lbi_in_t it);
    lbi_pkg::lbi_out_t res;
    longint d[3];
    longint mn, mx, e;
    bit [63:0] dist2, diag2, len, rem, q, s2, hd, dmax, num, r;
    longint co, so, cw, sw, sb, cb, cwo, swo, cp, ce, ci, si, cib;
    dist2 = 0;
    diag2 = 0;
    for (int i = 0; i < 3; i++) begin
      mn = lane_of(it.box_min, i);
      mx = lane_of(it.box_max, i);
      e = mx - mn;
      d[i] = 2 * lane_of(it.shade_point, i) - (mn + mx);
      dist2 += 64'(d[i] * d[i]);
      diag2 += 64'(e * e);
    end
    len = (dist2 != 0) ? floor_sqrt(dist2 << 28) : 64'd0;
    co = clamp_unit(longint'(it.cos_spread));
    so = sine_of(co);
    cw = dir_cos(d[0], d[1], d[2], it.cone_axis, len);
    if (it.two_sided && cw < 0) cw = -cw;
    sw = sine_of(cw);
    // Full sphere when the point sits inside the bounding sphere
    if (dist2 == 0 || dist2 < diag2) begin
      sb = 0;
      cb = -16384;
    end else begin
      rem = diag2;
      q = 0;
      if (rem >= dist2) begin
        rem -= dist2;
        q = 1;
      end
      for (int i = 0; i < 28; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= dist2) begin
          rem -= dist2;
          q[0] = 1'b1;
        end
      end
      s2 = q;
      sb = longint'(floor_sqrt(s2));
      cb = longint'(floor_sqrt(64'd268435456 - s2));
    end
    cwo = angle_cos(sw, cw, so, co);
    swo = angle_sin(sw, cw, so, co);
    cp = angle_cos(swo, cwo, sb, cb);
    ce = longint'(it.cos_falloff);
    if (cp <= ce) begin
      res.importance = '0;
      res.outside_falloff = 1'b1;
      return res;
    end
    ci = dir_cos(d[0], d[1], d[2], it.shade_normal, len);
    if (ci < 0) ci = -ci;
    si = sine_of(ci);
    cib = angle_cos(si, ci, sb, cb);
    hd = floor_sqrt(diag2 << 18);
    dmax = (dist2 > hd) ? dist2 : hd;
    res.outside_falloff = 1'b0;
    if (cib <= 0 || cp <= 0 || it.power == 0) begin
      res.importance = '0;
    end else begin
      num = 64'(it.power) * 64'(cib) * 64'(cp);
      if (dmax == 0) begin
        r = 64'hFFFF_FFFF;
      end else begin
        r = num / (dmax << 10);
        if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      end
      res.importance = r[31:0];
    end
    return res;
  endfunction

  function void note_input(lbi_pkg::lbi_in_t it);
    pending = {pending, estimate(it)};
  endfunction

  function void check_result(lbi_pkg::lbi_out_t got);
    lbi_pkg::lbi_out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result importance=%h outside_falloff=%b", $time,
               got.importance, got.outside_falloff);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.importance !== want.importance) begin
      $display("%0t: importance mismatch expected %h actual %h", $time,
               want.importance, got.importance);
      errors++;
    end
    if (got.outside_falloff !== want.outside_falloff) begin
      $display("%0t: outside_falloff mismatch expected %b actual %b", $time,
               want.outside_falloff, got.outside_falloff);
      errors++;
    end
    matched++;
  endfunction
endclass

module light_bounds_importance_tb;
  import lbi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  lbi_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  lbi_out_t out_data;

  importance_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycles;
  int unsigned sent;

  light_bounds_importance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [47:0] vec3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic lbi_in_t make_item(bit [47:0] bmin, bit [47:0] bmax, bit [47:0] axis,
                                        int spread, int falloff, bit [31:0] pwr, bit two,
                                        bit [47:0] pt, bit [47:0] nrm);
    lbi_in_t it;
    it.box_min = bmin;
    it.box_max = bmax;
    it.cone_axis = axis;
    it.cos_spread = 16'(spread);
    it.cos_falloff = 16'(falloff);
    it.power = pwr;
    it.two_sided = two;
    it.shade_point = pt;
    it.shade_normal = nrm;
    return it;
  endfunction

  function automatic int signed_range(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // Unit-ish direction: either along one axis or a random diagonal
  function automatic bit [47:0] rand_dir();
    int c[3];
    if ($urandom_range(1)) begin
      c = '{0, 0, 0};
      c[$urandom_range(2)] = $urandom_range(1) ? 16384 : -16384;
    end else begin
      foreach (c[i]) c[i] = $urandom_range(1) ? 9459 : -9459;
    end
    return vec3(c[0], c[1], c[2]);
  endfunction

  function automatic lbi_in_t rand_item();
    lbi_in_t it;
    logic [319:0] raw;
    int cx, cy, cz, hx, hy, hz;
    // Fully random bits now and then so that every field bit toggles
    if ($urandom_range(4) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      it = raw[$bits(lbi_in_t)-1:0];
      return it;
    end
    cx = signed_range(2000);
    cy = signed_range(2000);
    cz = signed_range(2000);
    hx = $urandom_range(300);
    hy = $urandom_range(300);
    hz = $urandom_range(300);
    it = make_item(vec3(cx - hx, cy - hy, cz - hz), vec3(cx + hx, cy + hy, cz + hz),
                   rand_dir(), signed_range(16384), signed_range(16384) - 8000, $urandom,
                   1'($urandom_range(1)),
                   vec3(cx + signed_range(3000), cy + signed_range(3000),
                        cz + signed_range(3000)),
                   rand_dir());
    if ($urandom_range(7) == 0) it.power = $urandom_range(255);
    return it;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(lbi_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  // Receiver: randomize ready at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    sb = new();
    cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners
    send_item(make_item('0, '0, '0, 0, 0, '0, 1'b0, '0, '0));
    send_item(make_item('1, '1, '1, -1, -1, '1, 1'b1, '1, '1));
    // Point at the centroid
    send_item(make_item(vec3(-100, -100, -100), vec3(100, 100, 100), vec3(0, 0, 16384),
                        16384, -16384, 32'h0001_0000, 1'b0, vec3(0, 0, 0),
                        vec3(16384, 0, 0)));
    // Point inside the bounding sphere
    send_item(make_item(vec3(-500, -500, -500), vec3(500, 500, 500), vec3(16384, 0, 0),
                        0, -16384, 32'h0004_0000, 1'b0, vec3(200, 100, 0),
                        vec3(-16384, 0, 0)));
    // Spread beyond the unit range, both ways
    send_item(make_item(vec3(0, 0, 0), vec3(10, 10, 10), vec3(0, 16384, 0), 32767,
                        -16384, 32'h0010_0000, 1'b0, vec3(0, 2000, 0),
                        vec3(0, -16384, 0)));
    send_item(make_item(vec3(0, 0, 0), vec3(10, 10, 10), vec3(0, 16384, 0), -32768,
                        16384, 32'h0010_0000, 1'b0, vec3(0, 2000, 0),
                        vec3(0, -16384, 0)));
    // Falloff extremes
    send_item(make_item(vec3(0, 0, 0), vec3(10, 10, 10), vec3(0, 16384, 0), 16000,
                        32767, 32'h0010_0000, 1'b0, vec3(0, 2000, 0), vec3(0, 16384, 0)));
    send_item(make_item(vec3(0, 0, 0), vec3(10, 10, 10), vec3(0, 16384, 0), 16000,
                        -32768, 32'h0010_0000, 1'b0, vec3(0, 2000, 0), vec3(0, 16384, 0)));
    // Emitter facing away, one- and two-sided
    send_item(make_item(vec3(0, 0, 0), vec3(4, 4, 4), vec3(0, -16384, 0), 16300, 0,
                        32'h0100_0000, 1'b0, vec3(0, 3000, 0), vec3(0, 16384, 0)));
    send_item(make_item(vec3(0, 0, 0), vec3(4, 4, 4), vec3(0, -16384, 0), 16300, 0,
                        32'h0100_0000, 1'b1, vec3(0, 3000, 0), vec3(0, 16384, 0)));
    // Non-unit vectors
    send_item(make_item(vec3(0, 0, 0), vec3(4, 4, 4), vec3(32767, 32767, 32767), 0,
                        -16384, 32'h0001_0000, 1'b0, vec3(900, 900, 900),
                        vec3(-32768, -32768, -32768)));
    // Zero power and maximum power
    send_item(make_item(vec3(0, 0, 0), vec3(4, 4, 4), vec3(16384, 0, 0), 0, -16384,
                        32'h0, 1'b0, vec3(500, 0, 0), vec3(16384, 0, 0)));
    send_item(make_item(vec3(0, 0, 0), vec3(2, 0, 0), vec3(16384, 0, 0), 0, -16384,
                        32'hFFFF_FFFF, 1'b0, vec3(2, 0, 0), vec3(16384, 0, 0)));
    // Point box at the point itself: zero denominator
    send_item(make_item(vec3(50, 60, 70), vec3(50, 60, 70), vec3(0, 0, 16384), 0,
                        -16384, 32'h0000_0001, 1'b0, vec3(50, 60, 70),
                        vec3(0, 0, 16384)));
    // Inverted box
    send_item(make_item(vec3(300, 300, 300), vec3(-300, -300, -300), vec3(16384, 0, 0),
                        8000, -8000, 32'h0020_0000, 1'b0, vec3(3000, 0, 0),
                        vec3(-16384, 0, 0)));
    // Lane extremes in the positions
    send_item(make_item(vec3(-32768, -32768, -32768), vec3(32767, 32767, 32767),
                        vec3(0, 0, -16384), -16384, -16384, 32'h8000_0000, 1'b1,
                        vec3(32767, -32768, 32767), vec3(0, 0, 16384)));
    send_item(make_item(vec3(32767, 32767, 32767), vec3(32767, 32767, 32767),
                        vec3(9459, 9459, 9459), 16384, -16384, 32'hFFFF_FFFF, 1'b0,
                        vec3(-32768, -32768, -32768), vec3(-9459, -9459, -9459)));

    // Hold off the sender until the pipe is empty
    drain();

    // Random items in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 25 : 0;
      for (int n = 0; n < 334; n++) send_item(rand_item());
    end
    drain();

    $display("Sent %0d items and checked %0d results across three idling phases.",
             sent, sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
